// ----- design/kef_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kef_pkg
// Shared types and constants for the keypad edge event FIFO.
// ----------------------------------------------------------------------------
package kef_pkg;

  localparam int NUM_SWITCHES = 9;
  localparam int KEY_IDX_W    = 4;
  localparam int STEP_W       = 5;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * NUM_SWITCHES - 1);
  localparam logic [STEP_W-1:0] STEP_SPLIT = STEP_W'(NUM_SWITCHES);

  typedef logic [NUM_SWITCHES-1:0] kef_scan_t;

  typedef struct packed {
    logic                 pressed;
    logic [KEY_IDX_W-1:0] index;
  } kef_event_t;

  localparam int EVENT_W = $bits(kef_event_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_READ,
    ST_WAIT,
    ST_PUBLISH
  } kef_state_t;

endpackage
`default_nettype wire

// ----- design/kef_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kef_scan_if / kef_event_if
// Valid/ready channels for switch scans and popped key events.
// ----------------------------------------------------------------------------
interface kef_scan_if;
  logic       valid;
  logic       ready;
  logic [8:0] switch_scan;

  modport source (output valid, output switch_scan, input ready);
  modport sink (input valid, input switch_scan, output ready);
endinterface

interface kef_event_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic [3:0] key_index;
  logic       key_pressed;

  modport source (output valid, output event_valid, output key_index,
                  output key_pressed, input ready);
  modport sink (input valid, input event_valid, input key_index,
                input key_pressed, output ready);
endinterface
`default_nettype wire

// ----- design/kef_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kef_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kef_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/keypad_edge_event_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_edge_event_fifo
// Turns switch scans into release and press events, queues them in a ring
// FIFO and pops at most one event per scan.
// ----------------------------------------------------------------------------
//  channel    direction  beat payload
//  in_scan    in         switch_scan
//  out_event  out        event_valid, key_index, key_pressed
//
// A scan beat is accepted in the idle step and then takes 18 push steps
// (releases of switches 0 to 8, then presses of switches 0 to 8) through one
// shared pointer increment and full compare, a read, a wait for the
// registered RAM read and a publish step. The result beat is registered
// when the output register is free; scan beats are only taken when idle.
// Reset clears the previous scan and both pointers; the event store is not.
// A result waits in the output register while the next scan is processed;
// a scan is held off only until that register frees.
// ----------------------------------------------------------------------------
module keypad_edge_event_fifo
  import kef_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input wire logic         clk,
  input wire logic         rst_n,
  kef_scan_if.sink         in_scan,
  kef_event_if.source      out_event
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  kef_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  kef_scan_t         prev_r, prev_nxt;
  kef_scan_t         rel_r, rel_nxt;
  kef_scan_t         prs_r, prs_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic              hit_r, hit_nxt;

  logic              out_valid_r, out_valid_nxt;
  kef_event_t        out_ev_r, out_ev_nxt;
  logic              out_hit_r, out_hit_nxt;

  logic              in_fire;
  logic              out_free;

  // Shared pointer unit: one increment with wrap and one compare.
  logic [PTR_W-1:0]  inc_in;
  logic [PTR_W-1:0]  inc_out;
  logic              inc_eq_rd;

  logic              is_press;
  logic [KEY_IDX_W-1:0] sw_idx;
  logic              sw_changed;

  logic              ram_we;
  kef_event_t        ram_wdata;
  logic [EVENT_W-1:0] ram_rdata;

  assign in_fire  = in_scan.valid && in_scan.ready;
  assign out_free = !out_valid_r || out_event.ready;

  assign is_press = (step_r >= STEP_SPLIT);
  assign sw_idx   = is_press ? KEY_IDX_W'(step_r - STEP_SPLIT) : KEY_IDX_W'(step_r);
  assign sw_changed = is_press ? prs_r[sw_idx] : rel_r[sw_idx];

  always_comb begin
    inc_in = (state_r == ST_WAIT) ? rd_ptr_r : wr_ptr_r;
    inc_out = (inc_in == PTR_LAST) ? '0 : inc_in + PTR_W'(1);
    inc_eq_rd = (inc_out == rd_ptr_r);
  end

  kef_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (ram_wdata),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:    state_nxt = ST_WAIT;
      ST_WAIT:    state_nxt = ST_PUBLISH;
      ST_PUBLISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    step_nxt      = step_r;
    prev_nxt      = prev_r;
    rel_nxt       = rel_r;
    prs_nxt       = prs_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    out_ev_nxt    = out_ev_r;
    out_hit_nxt   = out_hit_r;
    ram_we        = 1'b0;
    ram_wdata     = '{pressed: is_press, index: sw_idx};
    in_scan.ready = (state_r == ST_IDLE);

    if (out_valid_r && out_event.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          rel_nxt  = prev_r & ~in_scan.switch_scan;
          prs_nxt  = in_scan.switch_scan & ~prev_r;
          prev_nxt = in_scan.switch_scan;
          step_nxt = '0;
        end
      end
      ST_PUSH: begin
        step_nxt = step_r + STEP_W'(1);
        if (sw_changed && !inc_eq_rd) begin
          ram_we     = 1'b1;
          wr_ptr_nxt = inc_out;
        end
      end
      ST_READ: begin
        hit_nxt = (rd_ptr_r != wr_ptr_r);
      end
      ST_WAIT: begin
        out_ev_nxt = hit_r ? kef_event_t'(ram_rdata) : '0;
        if (hit_r) begin
          rd_ptr_nxt = inc_out;
        end
      end
      ST_PUBLISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
        end
      end
      default: begin
      end
    endcase
  end

  // The popped event is staged in out_ev_r during the wait step; it only
  // moves to the visible register once that register is free.
  kef_event_t shown_r, shown_nxt;

  always_comb begin
    shown_nxt = shown_r;
    if (state_r == ST_PUBLISH && out_free) begin
      shown_nxt = out_ev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      prev_r      <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      prev_r      <= prev_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rel_r     <= rel_nxt;
    prs_r     <= prs_nxt;
    hit_r     <= hit_nxt;
    out_ev_r  <= out_ev_nxt;
    out_hit_r <= out_hit_nxt;
    shown_r   <= shown_nxt;
  end

  assign out_event.valid       = out_valid_r;
  assign out_event.event_valid = out_hit_r;
  assign out_event.key_index   = shown_r.index;
  assign out_event.key_pressed = shown_r.pressed;

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keypad_edge_event_fifo. Switch scans are sent as
// beats on the scan channel with random gaps, while the event channel is
// stalled at random. A behavioral copy of the edge detector and the event
// ring predicts each popped event, and every event beat is compared with
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import kef_pkg::*;

  localparam int RING_DEPTH  = 16;
  localparam int RANDOM_SCANS = 1650;
  localparam int SHOW_LIMIT   = 10;

  typedef struct packed {
    logic                 event_valid;
    logic [KEY_IDX_W-1:0] key_index;
    logic                 key_pressed;
  } popped_event_t;

  logic clk;
  logic rst_n;

  kef_scan_if  scan_bus ();
  kef_event_if event_bus ();

  keypad_edge_event_fifo #(
    .FIFO_DEPTH (RING_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_scan   (scan_bus),
    .out_event (event_bus)
  );

  popped_event_t pending_events[$];
  kef_event_t    ring_copy[RING_DEPTH];
  kef_scan_t     last_scan;
  int            ring_rd;
  int            ring_wr;
  int            mismatch_count;
  bit            idle_on;
  int            stall_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("tb failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on) return 0;
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic ring_push(input int idx, input logic pressed);
    int nxt;
    nxt = (ring_wr == RING_DEPTH - 1) ? 0 : ring_wr + 1;
    if (nxt != ring_rd) begin
      ring_copy[ring_wr] = '{pressed: pressed, index: KEY_IDX_W'(idx)};
      ring_wr = nxt;
    end
  endtask

  task automatic predict_scan(input kef_scan_t scan);
    kef_scan_t     released;
    kef_scan_t     pressed;
    popped_event_t res;
    int            i;
    released  = last_scan & ~scan;
    pressed   = scan & ~last_scan;
    last_scan = scan;
    for (i = 0; i < NUM_SWITCHES; i++) begin
      if (released[i]) ring_push(i, 1'b0);
    end
    for (i = 0; i < NUM_SWITCHES; i++) begin
      if (pressed[i]) ring_push(i, 1'b1);
    end
    if (ring_rd == ring_wr) begin
      res = '0;
    end else begin
      res.event_valid = 1'b1;
      res.key_index   = ring_copy[ring_rd].index;
      res.key_pressed = ring_copy[ring_rd].pressed;
      ring_rd = (ring_rd == RING_DEPTH - 1) ? 0 : ring_rd + 1;
    end
    pending_events.push_back(res);
  endtask

  task automatic send_scan(input kef_scan_t scan);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      scan_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_bus.valid       <= 1'b1;
    scan_bus.switch_scan <= scan;
    @(posedge clk);
    while (!scan_bus.ready) @(posedge clk);
    predict_scan(scan);
  endtask

  // Each accepted event beat is checked against the oldest prediction.
  initial begin
    popped_event_t got;
    popped_event_t want;
    forever begin
      @(posedge clk);
      if (rst_n && event_bus.valid && event_bus.ready) begin
        got = '{event_bus.event_valid, event_bus.key_index, event_bus.key_pressed};
        if (pending_events.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display("unexpected event beat: valid=%0b index=%0d pressed=%0b",
                     got.event_valid, got.key_index, got.key_pressed);
        end else begin
          want = pending_events.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT)
              $display("event mismatch: expected valid=%0b index=%0d pressed=%0b, %s",
                       want.event_valid, want.key_index, want.key_pressed,
                       $sformatf("got valid=%0b index=%0d pressed=%0b",
                                 got.event_valid, got.key_index, got.key_pressed));
          end
        end
      end
    end
  end

  initial begin
    event_bus.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        event_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 15) begin
        stall_left = pick_gap();
        event_bus.ready <= 1'b0;
      end else begin
        event_bus.ready <= 1'b1;
      end
    end
  end

  task automatic test_empty_fifo();
    send_scan(9'h000);
    send_scan(9'h000);
  endtask

  task automatic test_all_edges();
    send_scan(9'h1FF);
    send_scan(9'h000);
  endtask

  task automatic test_overflow();
    send_scan(9'h1FF);
    send_scan(9'h000);
  endtask

  task automatic test_mixed_edges();
    send_scan(9'h0AA);
    send_scan(9'h155);
  endtask

  task automatic test_drain();
    repeat (16) send_scan(9'h155);
  endtask

  task automatic test_random();
    kef_scan_t scan;
    int        r;
    int        n;
    scan = last_scan;
    for (n = 0; n < RANDOM_SCANS; n++) begin
      if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        scan[$urandom_range(0, NUM_SWITCHES - 1)] ^= 1'b1;
      end else if (r < 70) begin
        scan[$urandom_range(0, NUM_SWITCHES - 1)] ^= 1'b1;
        scan[$urandom_range(0, NUM_SWITCHES - 1)] ^= 1'b1;
        scan[$urandom_range(0, NUM_SWITCHES - 1)] ^= 1'b1;
      end else if (r < 80) begin
        scan = kef_scan_t'($urandom_range(0, 511));
      end else if (r < 95) begin
        scan = scan;
      end else begin
        scan = (r[0]) ? 9'h1FF : 9'h000;
      end
      send_scan(scan);
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    scan_bus.valid       <= 1'b0;
    scan_bus.switch_scan <= '0;
    last_scan      = '0;
    ring_rd        = 0;
    ring_wr        = 0;
    mismatch_count = 0;
    idle_on        = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_fifo();
    test_all_edges();
    test_overflow();
    test_mixed_edges();
    test_drain();
    test_random();

    scan_bus.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
